>>> hdl/playfair_cipher_encoder_macros.svh
// Assertion macros for the playfair encoder top level.
// Depends on nothing; included by the top level, which carries the checks.
`ifndef PLAYFAIR_CIPHER_ENCODER_MACROS_SVH
`define PLAYFAIR_CIPHER_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFENC_ASSERT_SAME(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pfenc same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PFENC_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pfenc next-cycle check failed");

`endif

>>> hdl/pfenc_pkg.sv
// Shared constants, types and helper functions for the playfair encoder.
// Used by pfenc_ctrl, pfenc_dp and playfair_cipher_encoder.
`timescale 1ns / 1ps

package pfenc_pkg;

	localparam int SIDE    = 5;
	localparam int CELLS   = SIDE * SIDE;
	localparam int LETTERS = 26;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_BEGIN_KEY  = 3'd0;
	localparam logic [OP_W-1:0] OP_KEY_BYTE   = 3'd1;
	localparam logic [OP_W-1:0] OP_FINISH_KEY = 3'd2;
	localparam logic [OP_W-1:0] OP_PLAIN_BYTE = 3'd3;
	localparam logic [OP_W-1:0] OP_END_MSG    = 3'd4;

	typedef logic [4:0] letter_t;   // 0 = A
	typedef logic [4:0] pos_t;      // square position, 0..24
	typedef logic [2:0] rc_t;       // row or column, 0..4

	localparam letter_t CODE_I = 5'd8;
	localparam letter_t CODE_J = 5'd9;
	localparam letter_t CODE_X = 5'd23;

	localparam logic [7:0] UPPER_A = 8'd65;
	localparam logic [7:0] UPPER_Z = 8'd90;
	localparam logic [7:0] LOWER_A = 8'd97;
	localparam logic [7:0] LOWER_Z = 8'd122;
	localparam logic [6:0] CHAR_A  = 7'd65;
	localparam logic [6:0] CHAR_J  = 7'd74;

	typedef struct packed {
		logic take;        // capture the incoming word
		logic clear;       // begin key
		logic place_key;   // place the captured key letter
		logic scan_init;   // restart the alphabet scan
		logic scan_step;   // place the scan letter and advance
		logic pend_set;    // hold the captured letter as pending
		logic pend_clr;    // drop the pending letter
		logic pair_load;   // latch the pair to encrypt
		logic pair_x;      // second letter of the pair is filler X
		logic look;        // read both square positions
		logic rule;        // read both cipher letters from the square
		logic emit;        // load the output pair
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            letter;
		logic            ready;
		logic            pend_valid;
		logic            code_eq_pend;
		logic            scan_last;
		logic            ob_empty;
	} stat_t;

	function automatic pos_t pos_at(rc_t row, rc_t col);
		return pos_t'({row, 2'b00} + {2'b00, row} + {2'b00, col});
	endfunction

	function automatic rc_t pos_row(pos_t p);
		rc_t row;
		row = '0;
		for (int r = 1; r < SIDE; r++) begin
			if (p >= pos_t'(r * SIDE)) row = rc_t'(r);
		end
		return row;
	endfunction

	function automatic rc_t pos_col(pos_t p);
		return rc_t'(p - pos_at(pos_row(p), '0));
	endfunction

	function automatic rc_t wrap_inc(rc_t v);
		return (v == rc_t'(SIDE - 1)) ? '0 : rc_t'(v + 3'd1);
	endfunction

endpackage

>>> hdl/pfenc_ctrl.sv
// Controller state machine for the playfair encoder.
// Depends on pfenc_pkg; drives pfenc_dp through cmd_t, reads stat_t.
`timescale 1ns / 1ps

module pfenc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  pfenc_pkg::stat_t stat,
	output pfenc_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_LOOK = 3'd3;
	localparam logic [2:0] S_RULE = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (stat.op)
					pfenc_pkg::OP_BEGIN_KEY: begin
						cmd.clear = 1'b1;
					end
					pfenc_pkg::OP_KEY_BYTE: begin
						cmd.place_key = stat.letter;
					end
					pfenc_pkg::OP_FINISH_KEY: begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
					pfenc_pkg::OP_PLAIN_BYTE: begin
						if (stat.ready && stat.letter) begin
							if (!stat.pend_valid) begin
								cmd.pend_set = 1'b1;
							end else begin
								// pair with the pending letter; a doubled letter pairs with X and stays pending
								cmd.pair_load = 1'b1;
								cmd.pair_x    = stat.code_eq_pend;
								cmd.pend_clr  = !stat.code_eq_pend;
								state_d       = S_LOOK;
							end
						end
					end
					pfenc_pkg::OP_END_MSG: begin
						if (stat.ready && stat.pend_valid) begin
							cmd.pair_load = 1'b1;
							cmd.pair_x    = 1'b1;
							cmd.pend_clr  = 1'b1;
							state_d       = S_LOOK;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = S_IDLE;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_RULE;
			end
			S_RULE: begin
				cmd.rule = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				// hold until the previous pair has left
				if (stat.ob_empty) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/pfenc_dp.sv
// Datapath for the playfair encoder: key square, letter positions, pair rule,
// output pair register. Depends on pfenc_pkg; commanded by pfenc_ctrl.
`timescale 1ns / 1ps

module pfenc_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [2:0]       operation,
	input  logic [7:0]       char_byte,
	input  pfenc_pkg::cmd_t  cmd,
	output pfenc_pkg::stat_t stat,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [6:0]       cipher_char,
	output logic             pair_last
);

	// square contents and the reverse map letter -> position
	pfenc_pkg::letter_t key_sq_q [pfenc_pkg::CELLS];
	pfenc_pkg::pos_t    pos_q    [pfenc_pkg::LETTERS];

	logic [2:0]                    op_q;
	pfenc_pkg::letter_t            code_q;
	logic                          letter_q;
	logic [pfenc_pkg::LETTERS-1:0] used_q;
	pfenc_pkg::pos_t               fill_q;
	logic                          pend_v_q;
	pfenc_pkg::letter_t            pend_q;
	pfenc_pkg::letter_t            k_q;
	pfenc_pkg::letter_t            a_q, b_q;
	pfenc_pkg::pos_t               p1_q, p2_q;
	pfenc_pkg::letter_t            o1_q, o2_q;
	logic [6:0]                    ob1_q, ob2_q;
	logic [1:0]                    ob_cnt_q;

	logic               is_upper, is_lower;
	pfenc_pkg::letter_t fold_code;
	pfenc_pkg::letter_t place_code;
	logic               place_en;
	logic               sq_full;
	pfenc_pkg::rc_t     r1, c1, r2, c2;
	pfenc_pkg::pos_t    i1, i2;

	always_comb begin
		is_upper  = (char_byte >= pfenc_pkg::UPPER_A) && (char_byte <= pfenc_pkg::UPPER_Z);
		is_lower  = (char_byte >= pfenc_pkg::LOWER_A) && (char_byte <= pfenc_pkg::LOWER_Z);
		fold_code = is_upper ? 5'(char_byte - pfenc_pkg::UPPER_A)
			: 5'(char_byte - pfenc_pkg::LOWER_A);
		if (fold_code == pfenc_pkg::CODE_J) fold_code = pfenc_pkg::CODE_I;
	end

	assign sq_full    = (fill_q == pfenc_pkg::pos_t'(pfenc_pkg::CELLS));
	assign place_code = cmd.place_key ? code_q : k_q;
	assign place_en   = ((cmd.place_key && letter_q)
		|| (cmd.scan_step && (k_q != pfenc_pkg::CODE_J)))
		&& !sq_full && !used_q[place_code];

	always_comb begin
		r1 = pfenc_pkg::pos_row(p1_q);
		c1 = pfenc_pkg::pos_col(p1_q);
		r2 = pfenc_pkg::pos_row(p2_q);
		c2 = pfenc_pkg::pos_col(p2_q);
		if (r1 == r2) begin
			i1 = pfenc_pkg::pos_at(r1, pfenc_pkg::wrap_inc(c1));
			i2 = pfenc_pkg::pos_at(r2, pfenc_pkg::wrap_inc(c2));
		end else if (c1 == c2) begin
			i1 = pfenc_pkg::pos_at(pfenc_pkg::wrap_inc(r1), c1);
			i2 = pfenc_pkg::pos_at(pfenc_pkg::wrap_inc(r2), c2);
		end else begin
			i1 = pfenc_pkg::pos_at(r1, c2);
			i2 = pfenc_pkg::pos_at(r2, c1);
		end
	end

	// memories: one write, two registered reads
	always_ff @(posedge clk) begin
		if (place_en) begin
			key_sq_q[fill_q]  <= place_code;
			pos_q[place_code] <= fill_q;
		end
		if (cmd.look) begin
			p1_q <= pos_q[a_q];
			p2_q <= pos_q[b_q];
		end
		if (cmd.rule) begin
			o1_q <= key_sq_q[i1];
			o2_q <= key_sq_q[i2];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q     <= operation;
			code_q   <= fold_code;
			letter_q <= is_upper || is_lower;
		end
		if (cmd.pair_load) begin
			a_q <= pend_q;
			b_q <= cmd.pair_x ? pfenc_pkg::CODE_X : code_q;
		end
		if (cmd.emit) begin
			ob1_q <= pfenc_pkg::CHAR_A + {2'b00, o1_q};
			ob2_q <= pfenc_pkg::CHAR_A + {2'b00, o2_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			fill_q   <= '0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			k_q      <= '0;
			ob_cnt_q <= '0;
		end else begin
			if (cmd.clear) begin
				used_q   <= '0;
				fill_q   <= '0;
				pend_v_q <= 1'b0;
				pend_q   <= '0;
			end else begin
				if (place_en) begin
					used_q[place_code] <= 1'b1;
					fill_q             <= fill_q + 5'd1;
				end
				if (cmd.pend_set) begin
					pend_q   <= code_q;
					pend_v_q <= 1'b1;
				end else if (cmd.pend_clr) begin
					pend_v_q <= 1'b0;
				end
			end
			if (cmd.scan_init) begin
				k_q <= '0;
			end else if (cmd.scan_step) begin
				k_q <= k_q + 5'd1;
			end
			if (cmd.emit) begin
				ob_cnt_q <= 2'd2;
			end else if (rsp_valid && !rsp_stall) begin
				ob_cnt_q <= ob_cnt_q - 2'd1;
			end
		end
	end

	assign stat.op           = op_q;
	assign stat.letter       = letter_q;
	assign stat.ready        = sq_full;
	assign stat.pend_valid   = pend_v_q;
	assign stat.code_eq_pend = (code_q == pend_q);
	assign stat.scan_last    = (k_q == pfenc_pkg::letter_t'(pfenc_pkg::LETTERS - 1));
	assign stat.ob_empty     = (ob_cnt_q == 2'd0);

	assign rsp_valid   = (ob_cnt_q != 2'd0);
	assign cipher_char = (ob_cnt_q == 2'd2) ? ob1_q : ob2_q;
	assign pair_last   = (ob_cnt_q == 2'd1);

endmodule

>>> hdl/playfair_cipher_encoder.sv
// channel  | handshake           | payload
// req      | req_valid/req_stall | operation[2:0], char_byte[7:0]
// rsp      | rsp_valid/rsp_stall | cipher_char[6:0], pair_last
//
// A word without a result (begin key, key byte, ignored byte) needs only decode.
// Finish key then scans the alphabet, one scan step per cycle over 26 letters.
// A word that closes a pair goes through decode, position lookup, pair rule
// read of the square, then the output pair load; the load waits while the
// previous pair is still in the output register. Reset clears the used marks,
// fill count and pending letter; the square itself is rebuilt by key set-up.
// Top level; depends on pfenc_pkg, pfenc_ctrl, pfenc_dp and the macros header.
`timescale 1ns / 1ps
`include "playfair_cipher_encoder_macros.svh"

module playfair_cipher_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [2:0] operation,
	input  logic [7:0] char_byte,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [6:0] cipher_char,
	output logic       pair_last
);

	pfenc_pkg::cmd_t  cmd;
	pfenc_pkg::stat_t stat;

	pfenc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pfenc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (operation),
		.char_byte   (char_byte),
		.cmd         (cmd),
		.stat        (stat),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.cipher_char (cipher_char),
		.pair_last   (pair_last)
	);

	`PFENC_ASSERT_SAME(a_never_j, clk, arst_n, rsp_valid, cipher_char != pfenc_pkg::CHAR_J)
	`PFENC_ASSERT_NEXT(a_busy_after_take, clk, arst_n, req_valid && !req_stall, req_stall)
	`PFENC_ASSERT_NEXT(a_second_follows, clk, arst_n, rsp_valid && !rsp_stall && !pair_last, rsp_valid && pair_last)
	`PFENC_ASSERT_NEXT(a_gap_after_pair, clk, arst_n, rsp_valid && !rsp_stall && pair_last, !rsp_valid)

endmodule

>>> bench/playfair_cipher_encoder_test.sv
// Self-checking bench for the streaming playfair encoder: directed words, then
// random key set-ups and messages under sender idling and receiver stalls.
// Depends on pfenc_pkg and the playfair_cipher_encoder top level.
`timescale 1ns / 1ps

module playfair_cipher_encoder_test;

	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
	localparam int TEXT_WORDS = 850;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;
	localparam int LIMIT = 300000;

	typedef struct {
		logic [6:0] ch;
		logic       last;
	} cipher_t;

	// Tracks the key square and pairing state; queues the cipher letters due.
	class playfair_tracker;
		pfenc_pkg::letter_t grid[pfenc_pkg::CELLS];
		logic [pfenc_pkg::LETTERS-1:0] taken;
		int placed;
		bit held_ok;
		pfenc_pkg::letter_t held;
		cipher_t due[$];
		int errors;

		function new();
			foreach (grid[k]) grid[k] = '0;
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			taken = '0;
			placed = 0;
			held_ok = 1'b0;
			held = '0;
		endfunction

		function int letter_of(logic [7:0] b);
			int code;
			code = -1;
			if (b >= pfenc_pkg::UPPER_A && b <= pfenc_pkg::UPPER_Z)
				code = b - pfenc_pkg::UPPER_A;
			else if (b >= pfenc_pkg::LOWER_A && b <= pfenc_pkg::LOWER_Z)
				code = b - pfenc_pkg::LOWER_A;
			if (code == pfenc_pkg::CODE_J) code = pfenc_pkg::CODE_I;
			return code;
		endfunction

		function void settle(int code);
			if (placed >= pfenc_pkg::CELLS || taken[code]) return;
			grid[placed] = pfenc_pkg::letter_t'(code);
			placed++;
			taken[code] = 1'b1;
		endfunction

		function int cell_of(pfenc_pkg::letter_t c);
			for (int k = 0; k < pfenc_pkg::CELLS; k++) begin
				if (grid[k] == c) return k;
			end
			return 0;
		endfunction

		function void seal_pair(pfenc_pkg::letter_t a, pfenc_pkg::letter_t b);
			int p1, p2, r1, c1, r2, c2;
			pfenc_pkg::letter_t o1, o2;
			cipher_t w;
			p1 = cell_of(a);
			p2 = cell_of(b);
			r1 = p1 / pfenc_pkg::SIDE;
			c1 = p1 % pfenc_pkg::SIDE;
			r2 = p2 / pfenc_pkg::SIDE;
			c2 = p2 % pfenc_pkg::SIDE;
			if (r1 == r2) begin
				o1 = grid[r1 * pfenc_pkg::SIDE + (c1 + 1) % pfenc_pkg::SIDE];
				o2 = grid[r2 * pfenc_pkg::SIDE + (c2 + 1) % pfenc_pkg::SIDE];
			end else if (c1 == c2) begin
				o1 = grid[((r1 + 1) % pfenc_pkg::SIDE) * pfenc_pkg::SIDE + c1];
				o2 = grid[((r2 + 1) % pfenc_pkg::SIDE) * pfenc_pkg::SIDE + c2];
			end else begin
				o1 = grid[r1 * pfenc_pkg::SIDE + c2];
				o2 = grid[r2 * pfenc_pkg::SIDE + c1];
			end
			w.ch = pfenc_pkg::CHAR_A + 7'(o1);
			w.last = 1'b0;
			due.push_back(w);
			w.ch = pfenc_pkg::CHAR_A + 7'(o2);
			w.last = 1'b1;
			due.push_back(w);
		endfunction

		// Returns 1 when the word changes state or yields letters.
		function bit note_word(logic [2:0] op, logic [7:0] b);
			int code;
			int was;
			bit ready;
			code = letter_of(b);
			was = placed;
			ready = (placed == pfenc_pkg::CELLS);
			case (op)
				pfenc_pkg::OP_BEGIN_KEY: begin
					wipe();
					return 1'b1;
				end
				pfenc_pkg::OP_KEY_BYTE: begin
					if (code >= 0) settle(code);
					return placed != was;
				end
				pfenc_pkg::OP_FINISH_KEY: begin
					for (int k = 0; k < pfenc_pkg::LETTERS; k++) begin
						if (k != pfenc_pkg::CODE_J) settle(k);
					end
					return placed != was;
				end
				pfenc_pkg::OP_PLAIN_BYTE: begin
					if (!ready || code < 0) return 1'b0;
					if (!held_ok) begin
						held = pfenc_pkg::letter_t'(code);
						held_ok = 1'b1;
						return 1'b1;
					end
					// a doubled letter gets filler X and stays pending
					if (pfenc_pkg::letter_t'(code) == held) begin
						seal_pair(held, pfenc_pkg::CODE_X);
						return 1'b1;
					end
					held_ok = 1'b0;
					seal_pair(held, pfenc_pkg::letter_t'(code));
					return 1'b1;
				end
				pfenc_pkg::OP_END_MSG: begin
					if (!ready || !held_ok) return 1'b0;
					held_ok = 1'b0;
					seal_pair(held, pfenc_pkg::CODE_X);
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void check_letter(logic [6:0] ch, logic last);
			cipher_t want;
			if (due.size() == 0) begin
				$display("%0t: unexpected word: cipher_char expected none, actual %c last %0d",
					$time, ch, last);
				errors++;
				return;
			end
			want = due.pop_front();
			if (ch !== want.ch) begin
				$display("%0t: cipher_char mismatch: expected %c, actual %c (%h)",
					$time, want.ch, ch, ch);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: pair_last mismatch: expected %0d, actual %0d",
					$time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	logic [2:0] operation;
	logic [7:0] char_byte;
	logic       rsp_valid;
	logic       rsp_stall;
	logic [6:0] cipher_char;
	logic       pair_last;

	playfair_tracker tracker = new();
	int idle_pct;
	int stall_pct;
	int sent;
	int hold_asks;

	playfair_cipher_encoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.operation   (operation),
		.char_byte   (char_byte),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.cipher_char (cipher_char),
		.pair_last   (pair_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is asked for.
	initial begin : receiver
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin : monitor
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) tracker.check_letter(cipher_char, pair_last);
		end
	end

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] letter_byte(int code);
		return ($urandom_range(0, 1) ? pfenc_pkg::UPPER_A : pfenc_pkg::LOWER_A) + 8'(code);
	endfunction

	task automatic send_word(input logic [2:0] op, input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		char_byte <= b;
		do @(posedge clk); while (req_stall);
		void'(tracker.note_word(op, b));
		sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (tracker.due.size() != 0) @(posedge clk);
	endtask

	task automatic send_key();
		int len;
		int roll;
		int start;
		send_word(pfenc_pkg::OP_BEGIN_KEY, any_byte());
		if ($urandom_range(0, 7) == 0) begin
			// whole alphabet from a random start: square fills from key bytes alone
			start = $urandom_range(0, 25);
			for (int k = 0; k < pfenc_pkg::LETTERS; k++) begin
				send_word(pfenc_pkg::OP_KEY_BYTE,
					letter_byte((start + k) % pfenc_pkg::LETTERS));
			end
		end else begin
			len = $urandom_range(0, 14);
			for (int k = 0; k < len; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 85)
					send_word(pfenc_pkg::OP_KEY_BYTE, letter_byte($urandom_range(0, 25)));
				else send_word(pfenc_pkg::OP_KEY_BYTE, any_byte());
			end
		end
		if ($urandom_range(0, 9) == 0) send_word(pfenc_pkg::OP_FINISH_KEY, any_byte());
		send_word(pfenc_pkg::OP_FINISH_KEY, any_byte());
		if ($urandom_range(0, 9) == 0)
			send_word(pfenc_pkg::OP_KEY_BYTE, letter_byte($urandom_range(0, 25)));
	endtask

	task automatic send_message(input int len);
		int roll;
		int last_code;
		last_code = $urandom_range(0, 25);
		for (int k = 0; k < len; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				send_word(pfenc_pkg::OP_PLAIN_BYTE, letter_byte(last_code));
			end else if (roll < 20) begin
				last_code = pfenc_pkg::CODE_X;
				send_word(pfenc_pkg::OP_PLAIN_BYTE, letter_byte(last_code));
			end else if (roll < 28) begin
				send_word(pfenc_pkg::OP_PLAIN_BYTE, any_byte());
			end else if (roll < 31) begin
				send_word(pfenc_pkg::OP_END_MSG, any_byte());
			end else if (roll < 33) begin
				send_word(OP_FIRST_UNUSED + 3'($urandom_range(0, 2)), any_byte());
			end else if (roll < 34) begin
				send_word(pfenc_pkg::OP_BEGIN_KEY, any_byte());
			end else begin
				last_code = $urandom_range(0, 25);
				send_word(pfenc_pkg::OP_PLAIN_BYTE, letter_byte(last_code));
			end
		end
		send_word(pfenc_pkg::OP_END_MSG, any_byte());
	endtask

	task automatic run_session();
		if ($urandom_range(0, 9) == 0) begin
			// text before the square is complete must be dropped
			send_word(pfenc_pkg::OP_BEGIN_KEY, any_byte());
			repeat ($urandom_range(0, 4)) send_word(pfenc_pkg::OP_KEY_BYTE, any_byte());
			send_message($urandom_range(2, 6));
		end
		send_key();
		repeat ($urandom_range(1, 3)) send_message($urandom_range(2, 40));
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		req_valid = 1'b0;
		operation = pfenc_pkg::OP_BEGIN_KEY;
		char_byte = 8'h00;
		idle_pct = 0;
		stall_pct = 0;
		sent = 0;
		hold_asks = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before any key: dropped
		send_word(pfenc_pkg::OP_PLAIN_BYTE, "A");
		send_word(pfenc_pkg::OP_END_MSG, 8'h00);
		send_word(OP_LAST_UNUSED, 8'hFF);
		send_word(pfenc_pkg::OP_BEGIN_KEY, 8'h00);
		send_word(pfenc_pkg::OP_KEY_BYTE, "P");
		send_word(pfenc_pkg::OP_KEY_BYTE, "l");
		send_word(pfenc_pkg::OP_KEY_BYTE, "A");
		send_word(pfenc_pkg::OP_KEY_BYTE, "y");
		send_word(pfenc_pkg::OP_KEY_BYTE, "J");
		send_word(pfenc_pkg::OP_KEY_BYTE, "i");
		send_word(pfenc_pkg::OP_KEY_BYTE, 8'hFF);
		send_word(pfenc_pkg::OP_KEY_BYTE, "Z");
		send_word(pfenc_pkg::OP_FINISH_KEY, 8'h00);
		send_word(pfenc_pkg::OP_FINISH_KEY, 8'hFF);
		send_word(pfenc_pkg::OP_KEY_BYTE, "Q");
		// same row, same column, doubled letter, doubled X
		send_word(pfenc_pkg::OP_PLAIN_BYTE, "A");
		send_word(pfenc_pkg::OP_PLAIN_BYTE, "y");
		send_word(pfenc_pkg::OP_PLAIN_BYTE, "P");
		send_word(pfenc_pkg::OP_PLAIN_BYTE, "z");
		send_word(pfenc_pkg::OP_PLAIN_BYTE, "E");
		send_word(pfenc_pkg::OP_PLAIN_BYTE, "e");
		send_word(pfenc_pkg::OP_PLAIN_BYTE, "{");
		send_word(pfenc_pkg::OP_END_MSG, 8'h00);
		send_word(pfenc_pkg::OP_END_MSG, 8'h00);
		send_word(pfenc_pkg::OP_PLAIN_BYTE, "x");
		send_word(pfenc_pkg::OP_PLAIN_BYTE, "X");
		send_word(pfenc_pkg::OP_END_MSG, 8'hFF);
		drain();

		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 53; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 53; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			// hold the receiver off while words keep coming
			if (phase == 0 || phase == 3) hold_asks++;
			while (sent < TEXT_WORDS * (phase + 1) / 4) run_session();
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/pfenc_pkg.sv
hdl/pfenc_ctrl.sv
hdl/pfenc_dp.sv
hdl/playfair_cipher_encoder.sv
bench/playfair_cipher_encoder_test.sv
